### rtl/core/elpd_pkg.sv
// elpd_pkg: shared codes, widths and control structs for the edge long press detector
// no dependencies; imported by elpd_timer, edge_long_press_detector, long_press_checker and tb_top
package elpd_pkg;

  // input action codes
  localparam logic [1:0] ACT_FALLING = 2'd0;
  localparam logic [1:0] ACT_RISING  = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  // reported event codes
  localparam logic [1:0] EV_FALLING    = 2'd0;
  localparam logic [1:0] EV_RISING     = 2'd1;
  localparam logic [1:0] EV_LONG_PRESS = 2'd2;
  localparam logic [1:0] EV_RELEASE    = 2'd3;

  // long press arming edge codes
  localparam logic [1:0] LPE_NONE    = 2'd0;
  localparam logic [1:0] LPE_FALLING = 2'd1;
  localparam logic [1:0] LPE_RISING  = 2'd2;

  // configuration register indexes and port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LP_EDGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LP_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTH_EDGES = 2'd3;

  // timer control from the front end
  typedef struct packed {
    logic arm;
    logic tick;
    logic level;
  } tmr_ctrl_t;

  // timer status back to the front end
  typedef struct packed {
    logic fire;
  } tmr_stat_t;

endpackage

### rtl/core/elpd_timer.sv
// elpd_timer: long press countdown with held level and repeat reload
// depends on elpd_pkg for the control and status structs
module elpd_timer #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  elpd_pkg::tmr_ctrl_t            ctrl,
  input  logic [elpd_pkg::CFG_DATA_W-1:0] timeout,
  input  logic [elpd_pkg::CFG_DATA_W-1:0] repeat_ival,
  output elpd_pkg::tmr_stat_t            stat
);
  import elpd_pkg::*;

  localparam int CW = TICK_COUNT_WIDTH;
  localparam int LW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam logic [LW-1:0] CMAX = LW'({CW{1'b1}});

  logic          running_r, running_nxt;
  logic          held_r, held_nxt;
  logic [CW-1:0] ticks_r, ticks_nxt;
  logic [CW-1:0] load_timeout;
  logic [CW-1:0] load_repeat;
  logic [LW-1:0] ext_timeout;
  logic [LW-1:0] ext_repeat;
  logic          expire;

  // load values saturate to the counter range
  assign ext_timeout  = LW'(timeout);
  assign ext_repeat   = LW'(repeat_ival);
  assign load_timeout = (ext_timeout > CMAX) ? CW'(CMAX) : CW'(ext_timeout);
  assign load_repeat  = (ext_repeat > CMAX) ? CW'(CMAX) : CW'(ext_repeat);

  // a count of one or zero on a tick means expiry
  assign expire    = ctrl.tick && running_r && (ticks_r <= CW'(1));
  assign stat.fire = expire && (ctrl.level == held_r);

  // next countdown state
  always_comb begin
    running_nxt = running_r;
    held_nxt    = held_r;
    ticks_nxt   = ticks_r;
    if (ctrl.arm) begin
      held_nxt    = ctrl.level;
      ticks_nxt   = load_timeout;
      running_nxt = 1'b1;
    end else if (ctrl.tick && running_r) begin
      if (!expire) begin
        ticks_nxt = ticks_r - CW'(1);
      end else if (ctrl.level != held_r) begin
        ticks_nxt   = '0;
        running_nxt = 1'b0;
      end else if (repeat_ival != '0) begin
        ticks_nxt = load_repeat;
      end else begin
        ticks_nxt   = '0;
        running_nxt = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      held_r    <= 1'b0;
      ticks_r   <= '0;
    end else begin
      running_r <= running_nxt;
      held_r    <= held_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

endmodule

### rtl/core/edge_long_press_detector.sv
// edge_long_press_detector: edge reporting, long press timing and release swallowing
// depends on elpd_pkg and elpd_timer
// a result is registered into out_event_kind in the cycle after its item transfer
// throughput: one item per cycle while out_ready is high; the single output register is refilled while drained
// items that yield no result (idle ticks, action code 3) are taken without output
// reset (synchronous, rst_n low): timer stopped, flags clear, output empty,
// registers at long_press_edge 0, timeout 0, repeat 0, both_edges_watched 1
module edge_long_press_detector #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [elpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [elpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic                             in_line_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_event_kind
);
  import elpd_pkg::*;

  logic [1:0]            lp_edge_r;
  logic [CFG_DATA_W-1:0] timeout_r;
  logic [CFG_DATA_W-1:0] repeat_r;
  logic                  both_r;
  logic                  swallow_r, swallow_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic                  accept, is_edge, is_tick, release_ev, edge_match, has_res;
  tmr_ctrl_t             tctrl;
  tmr_stat_t             tstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_edge_r <= LPE_NONE;
      timeout_r <= '0;
      repeat_r  <= '0;
      both_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LP_EDGE:    lp_edge_r <= cfg_wdata[1:0];
        REG_LP_TIMEOUT: timeout_r <= cfg_wdata;
        REG_REPEAT:     repeat_r  <= cfg_wdata;
        REG_BOTH_EDGES: both_r    <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  // transfer when the output register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_edge  = (in_action == ACT_FALLING) || (in_action == ACT_RISING);
  assign is_tick  = (in_action == ACT_TICK);

  // edge decode
  assign release_ev = is_edge && swallow_r;
  assign edge_match = (in_action == ACT_FALLING) ? (lp_edge_r == LPE_FALLING)
                                                 : (lp_edge_r == LPE_RISING);

  // timer control
  assign tctrl.arm   = accept && is_edge && !swallow_r && edge_match && (timeout_r != '0);
  assign tctrl.tick  = accept && is_tick;
  assign tctrl.level = in_line_level;

  elpd_timer #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (tctrl),
    .timeout    (timeout_r),
    .repeat_ival(repeat_r),
    .stat       (tstat)
  );

  // swallow flag and result selection
  always_comb begin
    swallow_nxt = swallow_r;
    if (accept && release_ev) begin
      swallow_nxt = 1'b0;
    end else if (tstat.fire && both_r) begin
      swallow_nxt = 1'b1;
    end
    has_res = accept && (is_edge || tstat.fire);
    if (release_ev) begin
      kind_nxt = EV_RELEASE;
    end else if (in_action == ACT_FALLING) begin
      kind_nxt = EV_FALLING;
    end else if (in_action == ACT_RISING) begin
      kind_nxt = EV_RISING;
    end else begin
      kind_nxt = EV_LONG_PRESS;
    end
    if (has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swallow_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      swallow_r   <= swallow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (has_res) begin
      kind_r <= kind_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;

endmodule

### tb/sv/long_press_checker.sv
// long_press_checker: watches the item, result and register ports of the long press detector
// predicts each reported event and compares it with the result stream; depends on elpd_pkg
`timescale 1ns / 1ps

module long_press_checker #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [elpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [elpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic                             in_line_level,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       out_event_kind,
  output int                               events_due,
  output int                               fail_count
);
  import elpd_pkg::*;

  localparam logic [TICK_COUNT_WIDTH-1:0] TICKS_MAX = '1;

  // register copies
  logic [1:0]  lp_edge;
  logic [15:0] lp_timeout;
  logic [15:0] rep_ivl;
  logic        both_watch;

  // predicted detector state
  logic                        tmr_run;
  logic [TICK_COUNT_WIDTH-1:0] ticks_rem;
  logic                        held_lvl;
  logic                        swallow;

  // events still owed by the block, oldest first
  logic [1:0] event_q[$];

  // load a countdown value, clamped to the counter range
  function automatic logic [TICK_COUNT_WIDTH-1:0] clamp_ticks(input logic [15:0] val);
    if (32'(val) > 32'(TICKS_MAX)) return TICKS_MAX;
    return TICK_COUNT_WIDTH'(val);
  endfunction

  // advance the detector by one item; has_ev tells whether an event is reported
  function automatic void predict_event(input logic [1:0] act, input logic lvl,
                                        output logic has_ev, output logic [1:0] ev);
    has_ev = 1'b0;
    ev     = EV_FALLING;
    if (act == ACT_FALLING || act == ACT_RISING) begin
      has_ev = 1'b1;
      if (swallow) begin
        swallow = 1'b0;
        ev      = EV_RELEASE;
      end else begin
        ev = (act == ACT_FALLING) ? EV_FALLING : EV_RISING;
        if (((act == ACT_FALLING && lp_edge == LPE_FALLING) ||
             (act == ACT_RISING && lp_edge == LPE_RISING)) && lp_timeout != 16'd0) begin
          held_lvl  = lvl;
          ticks_rem = clamp_ticks(lp_timeout);
          tmr_run   = 1'b1;
        end
      end
    end else if (act == ACT_TICK && tmr_run) begin
      if (ticks_rem > 1) begin
        ticks_rem = ticks_rem - 1'b1;
      end else begin
        ticks_rem = '0;
        if (lvl != held_lvl) begin
          // line moved away from the armed level: drop silently
          tmr_run = 1'b0;
        end else begin
          if (both_watch) swallow = 1'b1;
          if (rep_ivl != 16'd0) ticks_rem = clamp_ticks(rep_ivl);
          else tmr_run = 1'b0;
          has_ev = 1'b1;
          ev     = EV_LONG_PRESS;
        end
      end
    end
  endfunction

  // observe transfers on every edge
  always @(posedge clk) begin : watch
    logic       has_ev;
    logic [1:0] ev;
    logic [1:0] want;
    if (!rst_n) begin
      lp_edge    = LPE_NONE;
      lp_timeout = '0;
      rep_ivl    = '0;
      both_watch = 1'b1;
      tmr_run    = 1'b0;
      ticks_rem  = '0;
      held_lvl   = 1'b0;
      swallow    = 1'b0;
      event_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LP_EDGE:    lp_edge    = cfg_wdata[1:0];
          REG_LP_TIMEOUT: lp_timeout = cfg_wdata[15:0];
          REG_REPEAT:     rep_ivl    = cfg_wdata[15:0];
          REG_BOTH_EDGES: both_watch = cfg_wdata[0];
          default: ;
        endcase
      end
      // result transfer: belongs to an item taken on an earlier edge
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected event: got %0d with nothing owed", $time, out_event_kind);
        end else begin
          want = event_q.pop_front();
          if (out_event_kind !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] event_kind mismatch: expected %0d got %0d",
                       $time, want, out_event_kind);
          end
        end
      end
      // item transfer
      if (in_valid && in_ready) begin
        predict_event(in_action, in_line_level, has_ev, ev);
        if (has_ev) event_q.push_back(ev);
      end
    end
    events_due = event_q.size();
  end

  initial begin
    events_due = 0;
    fail_count = 0;
  end

endmodule

### tb/sv/tb_top.sv
// tb_top: stimulus and verdict for edge_long_press_detector
// depends on elpd_pkg, the detector RTL and long_press_checker
`timescale 1ns / 1ps

module tb_top;
  import elpd_pkg::*;

  localparam int         TARGET_ITEMS = 1450;
  localparam int         STALL_LIMIT  = 2000;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [1:0] LPE_UNUSED   = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = ACT_FALLING;
  logic                  in_line_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_event_kind;

  int events_due;
  int fail_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int item_count = 0;
  int quiet_cycles = 0;

  // current register settings, used to size the press sequences
  logic [1:0]  cur_edge;
  logic [15:0] cur_timeout;
  logic [15:0] cur_repeat;

  edge_long_press_detector u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_line_level  (in_line_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind)
  );

  long_press_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_line_level  (in_line_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .events_due     (events_due),
    .fail_count     (fail_count)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles with work outstanding but no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (in_valid || events_due > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 59; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 59; end
      default: begin idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  // one item transfer; called and returns on a rising edge
  task automatic send_item(input logic [1:0] act, input logic lvl);
    logic took;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_line_level <= lvl;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    if (act != ACT_UNUSED) item_count++;
  endtask

  // wait until every owed event has come back, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (events_due != 0);
    repeat (3) @(posedge clk);
  endtask

  // write all four registers on consecutive edges while the block is idle
  task automatic write_regs(input logic [1:0] lp_edge, input logic [15:0] tmo,
                            input logic [15:0] rep, input logic both);
    cur_edge    = lp_edge;
    cur_timeout = tmo;
    cur_repeat  = rep;
    cfg_we    <= 1'b1;
    cfg_index <= REG_LP_EDGE;
    cfg_wdata <= CFG_DATA_W'(lp_edge);
    @(posedge clk);
    cfg_index <= REG_LP_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= REG_REPEAT;
    cfg_wdata <= rep;
    @(posedge clk);
    cfg_index <= REG_BOTH_EDGES;
    cfg_wdata <= CFG_DATA_W'(both);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // press, hold through ticks (level mostly steady), release
  task automatic press_sequence;
    logic [1:0] arm_act;
    logic [1:0] rel_act;
    logic       lv;
    int         hold;
    if (cur_edge == LPE_FALLING) arm_act = ACT_FALLING;
    else if (cur_edge == LPE_RISING) arm_act = ACT_RISING;
    else arm_act = $urandom_range(1) ? ACT_RISING : ACT_FALLING;
    rel_act = (arm_act == ACT_FALLING) ? ACT_RISING : ACT_FALLING;
    lv   = $urandom_range(1);
    hold = $urandom_range(0, int'(cur_timeout) + 3 * int'(cur_repeat) + 2);
    send_item(arm_act, lv);
    repeat (hold) send_item(ACT_TICK, ($urandom_range(19) == 0) ? ~lv : lv);
    if ($urandom_range(9) != 0) send_item(rel_act, ~lv);
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_items;
    logic [1:0] edge_sel;
    logic [15:0] tmo;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default registers, nothing arms
    send_item(ACT_FALLING, 1'b0);
    send_item(ACT_RISING, 1'b1);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_UNUSED, 1'b0);
    drain();

    // directed: falling arms, repeat every tick, release swallowed
    write_regs(LPE_FALLING, 16'd2, 16'd1, 1'b1);
    send_item(ACT_FALLING, 1'b0);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_RISING, 1'b1);
    send_item(ACT_RISING, 1'b1);
    // level changed at expiry: timer stops quietly
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_TICK, 1'b1);
    // falling edge re-arms; a non-arming edge leaves the countdown alone
    send_item(ACT_FALLING, 1'b0);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_RISING, 1'b1);
    send_item(ACT_TICK, 1'b0);
    send_item(ACT_UNUSED, 1'b1);
    send_item(ACT_RISING, 1'b1);
    drain();

    // directed: rising arms, single shot, no swallowing
    write_regs(LPE_RISING, 16'd1, 16'd0, 1'b0);
    send_item(ACT_RISING, 1'b1);
    send_item(ACT_TICK, 1'b1);
    send_item(ACT_FALLING, 1'b0);
    send_item(ACT_TICK, 1'b0);
    drain();

    // directed: longest timeout and repeat interval
    write_regs(LPE_FALLING, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(ACT_FALLING, 1'b1);
    repeat (8) send_item(ACT_TICK, 1'b1);
    send_item(ACT_RISING, 1'b0);
    drain();
    item_count = 0;

    // random phases: mostly press sequences, some noise
    phase = 0;
    while (item_count < TARGET_ITEMS) begin
      case (phase % 6)
        0, 2: edge_sel = LPE_FALLING;
        1, 3: edge_sel = LPE_RISING;
        4:    edge_sel = LPE_NONE;
        default: edge_sel = LPE_UNUSED;
      endcase
      tmo = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      write_regs(edge_sel, tmo, 16'($urandom_range(0, 4)), 1'($urandom_range(1)));
      set_idling(phase % 4);
      phase_items = item_count;
      while (item_count - phase_items < 120 && item_count < TARGET_ITEMS) begin
        if ($urandom_range(4) != 0) press_sequence();
        else send_item(2'($urandom_range(3)), 1'($urandom_range(1)));
      end
      drain();
      phase++;
    end

    set_idling(0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
